>>> rtl/iir4_pkg.sv
// shared constants, register indexes and the mac control bundle for the
// fourth-order direct form ii iir filter; no dependencies
package iir4_pkg;

   localparam int SAMPLE_WIDTH   = 24;
   localparam int STATE_WIDTH    = 28;
   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_WIDTH     = 18;
   localparam int TAP_COUNT      = 5;
   localparam int POLE_COUNT     = 4;
   localparam int IDX_WIDTH      = $clog2(TAP_COUNT);

   // full product, rounded product and accumulator widths
   localparam int PROD_WIDTH = COEF_WIDTH + STATE_WIDTH;
   localparam int RND_WIDTH  = PROD_WIDTH + 1 - COEF_FRAC_BITS;
   localparam int ACC_BASE_A = (RND_WIDTH > SAMPLE_WIDTH) ? RND_WIDTH : SAMPLE_WIDTH;
   localparam int ACC_BASE   = (ACC_BASE_A > STATE_WIDTH) ? ACC_BASE_A : STATE_WIDTH;
   localparam int ACC_WIDTH  = ACC_BASE + 4;

   // register file
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_ADDR_WIDTH  = CSR_INDEX_WIDTH + 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_TAP0      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_TAP1      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_TAP2      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_TAP3      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_TAP4      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEN_PAIR_LOW  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEN_PAIR_HIGH = 3'd6;

   typedef struct packed {
      logic issue;  // start a multiply this cycle
      logic sub;    // subtract the product from the accumulator
      logic load;   // overwrite the accumulator with the load value
   } mac_ctrl_type;

endpackage

>>> rtl/iir4_stream_if.sv
// valid/ready channel interfaces for the iir filter sample and result beats
// depends on iir4_pkg
interface iir4_req_if;
   import iir4_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir4_rsp_if;
   import iir4_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           saturated;

   modport source (output valid, output sample_out, output saturated, input ready);
   modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

>>> rtl/iir4_mac.sv
// shared multiply-accumulate unit: registered coefficient x state product,
// round half up at the fraction point, accumulate; depends on iir4_pkg
module iir4_mac (
   input  logic                                     clock,
   input  logic                                     reset,
   input  iir4_pkg::mac_ctrl_type                   ctrl,
   input  logic signed [iir4_pkg::COEF_WIDTH-1:0]   coef,
   input  logic signed [iir4_pkg::STATE_WIDTH-1:0]  operand,
   input  logic signed [iir4_pkg::ACC_WIDTH-1:0]    load_value,
   output logic signed [iir4_pkg::ACC_WIDTH-1:0]    acc
);
   import iir4_pkg::*;

   localparam logic [PROD_WIDTH:0] RND_BIAS = (PROD_WIDTH + 1)'(1) << (COEF_FRAC_BITS - 1);

   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic                         prod_vld_ff, prod_vld_in;
   logic                         prod_sub_ff, prod_sub_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_in;
   logic        [PROD_WIDTH:0]   biased;
   logic        [RND_WIDTH-1:0]  rnd;
   logic signed [ACC_WIDTH-1:0]  rnd_ext;

   assign prod_in     = PROD_WIDTH'(coef * operand);
   assign prod_vld_in = ctrl.issue;
   assign prod_sub_in = ctrl.sub;

   // floor((p + half) / 2^frac) on the sign-extended product
   assign biased  = {prod_ff[PROD_WIDTH-1], prod_ff} + RND_BIAS;
   assign rnd     = biased[PROD_WIDTH:COEF_FRAC_BITS];
   assign rnd_ext = {{(ACC_WIDTH - RND_WIDTH){rnd[RND_WIDTH-1]}}, rnd};

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = load_value;
      end else if (prod_vld_ff) begin
         acc_in = prod_sub_ff ? (acc_ff - rnd_ext) : (acc_ff + rnd_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
      prod_ff     <= prod_in;
      prod_sub_ff <= prod_sub_in;
      acc_ff      <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> rtl/iir_fourth_order_direct_form_two_unit.sv
// top level of the fourth-order direct form ii iir filter: register file,
// sequencer, delay line and saturation; depends on iir4_pkg, iir4_stream_if, iir4_mac
//
// One sample beat in gives one result beat out. With delay line w1..w4 the
// filter forms w = u - d0*w1 - d1*w2 - d2*w3 - d3*w4 and then
// y = n0*w + n1*w1 + ... + n4*w4, each product rounded half up at the
// 14-bit fraction point. w is clipped to 28 bits signed and y to 24 bits
// signed; saturated flags either clip. A single 18x28 multiplier with an
// accumulator behind it does all nine products, one per cycle, in these steps
// after acceptance: the four pole products, a drain, the state clip, the five
// zero products, a drain and the output clip, which waits for a free output
// register before the filter is ready again. The result sits in an output
// register, so the next sample can be accepted while it waits. Coefficients
// are written over the apb-style port at byte address 8*index (num_tap0..4
// at 0..32, den_pair_low at 40 with d0 in bits 17:0 and d1 in 35:18,
// den_pair_high at 48 with d2 and d3). The user must write them only while
// the filter is idle; the block does not enforce it. pready is always high
// and reads return the stored value. Coefficients and delay line reset to zero.
module iir_fourth_order_direct_form_two_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   iir4_req_if.sink                                req_if,
   iir4_rsp_if.source                              rsp_if,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [iir4_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [iir4_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [iir4_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                    pready
);
   import iir4_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_POLE   = 7'b0000010,
      S_PDRAIN = 7'b0000100,
      S_WSAT   = 7'b0001000,
      S_ZERO   = 7'b0010000,
      S_ZDRAIN = 7'b0100000,
      S_YSAT   = 7'b1000000
   } state_type;

   // clip limits in accumulator width
   localparam logic signed [ACC_WIDTH-1:0] W_MAX =
      {{(ACC_WIDTH - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] W_MIN =
      {{(ACC_WIDTH - STATE_WIDTH + 1){1'b1}}, {(STATE_WIDTH - 1){1'b0}}};
   localparam logic signed [ACC_WIDTH-1:0] Y_MAX =
      {{(ACC_WIDTH - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] Y_MIN =
      {{(ACC_WIDTH - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

   // coefficient registers
   logic signed [COEF_WIDTH-1:0] num_ff [TAP_COUNT];
   logic signed [COEF_WIDTH-1:0] num_in [TAP_COUNT];
   logic signed [COEF_WIDTH-1:0] den_ff [POLE_COUNT];
   logic signed [COEF_WIDTH-1:0] den_in [POLE_COUNT];

   // filter state, w1 at index 0
   logic signed [STATE_WIDTH-1:0] dl_ff [POLE_COUNT];
   logic signed [STATE_WIDTH-1:0] dl_in [POLE_COUNT];

   state_type                     state_ff, state_in;
   logic [IDX_WIDTH-1:0]          idx_ff, idx_in;
   logic signed [STATE_WIDTH-1:0] w_ff, w_in;
   logic                          clip_ff, clip_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_ff, sample_out_in;
   logic                          saturated_ff, saturated_in;

   mac_ctrl_type                  mac_ctrl;
   logic signed [COEF_WIDTH-1:0]  mac_coef;
   logic signed [STATE_WIDTH-1:0] mac_operand;
   logic signed [ACC_WIDTH-1:0]   mac_load;
   logic signed [ACC_WIDTH-1:0]   acc;

   logic                          cfg_write;
   logic [CSR_INDEX_WIDTH-1:0]    cfg_index;
   logic                          req_beat;
   logic                          out_free;
   logic                          w_over;
   logic                          y_over;
   logic signed [STATE_WIDTH-1:0] w_clip;
   logic signed [SAMPLE_WIDTH-1:0] y_clip;

   // ---------------------------------------------------------------------
   // register file
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = paddr[CSR_ADDR_WIDTH-1:3];

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            REG_NUM_TAP0:      num_in[0] = pwdata[COEF_WIDTH-1:0];
            REG_NUM_TAP1:      num_in[1] = pwdata[COEF_WIDTH-1:0];
            REG_NUM_TAP2:      num_in[2] = pwdata[COEF_WIDTH-1:0];
            REG_NUM_TAP3:      num_in[3] = pwdata[COEF_WIDTH-1:0];
            REG_NUM_TAP4:      num_in[4] = pwdata[COEF_WIDTH-1:0];
            REG_DEN_PAIR_LOW: begin
               den_in[0] = pwdata[COEF_WIDTH-1:0];
               den_in[1] = pwdata[2*COEF_WIDTH-1:COEF_WIDTH];
            end
            REG_DEN_PAIR_HIGH: begin
               den_in[2] = pwdata[COEF_WIDTH-1:0];
               den_in[3] = pwdata[2*COEF_WIDTH-1:COEF_WIDTH];
            end
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         REG_NUM_TAP0: prdata = {{(CSR_DATA_WIDTH - COEF_WIDTH){1'b0}}, num_ff[0]};
         REG_NUM_TAP1: prdata = {{(CSR_DATA_WIDTH - COEF_WIDTH){1'b0}}, num_ff[1]};
         REG_NUM_TAP2: prdata = {{(CSR_DATA_WIDTH - COEF_WIDTH){1'b0}}, num_ff[2]};
         REG_NUM_TAP3: prdata = {{(CSR_DATA_WIDTH - COEF_WIDTH){1'b0}}, num_ff[3]};
         REG_NUM_TAP4: prdata = {{(CSR_DATA_WIDTH - COEF_WIDTH){1'b0}}, num_ff[4]};
         REG_DEN_PAIR_LOW:
            prdata = {{(CSR_DATA_WIDTH - 2*COEF_WIDTH){1'b0}}, den_ff[1], den_ff[0]};
         REG_DEN_PAIR_HIGH:
            prdata = {{(CSR_DATA_WIDTH - 2*COEF_WIDTH){1'b0}}, den_ff[3], den_ff[2]};
         default: prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // shared multiply-accumulate
   // ---------------------------------------------------------------------
   iir4_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .coef       (mac_coef),
      .operand    (mac_operand),
      .load_value (mac_load),
      .acc        (acc)
   );

   // coefficient and operand select for the current tap
   always_comb begin
      mac_coef    = '0;
      mac_operand = '0;
      if (state_ff == S_POLE) begin
         case (idx_ff)
            3'd0:    begin mac_coef = den_ff[0]; mac_operand = dl_ff[0]; end
            3'd1:    begin mac_coef = den_ff[1]; mac_operand = dl_ff[1]; end
            3'd2:    begin mac_coef = den_ff[2]; mac_operand = dl_ff[2]; end
            default: begin mac_coef = den_ff[3]; mac_operand = dl_ff[3]; end
         endcase
      end else begin
         case (idx_ff)
            3'd0:    begin mac_coef = num_ff[0]; mac_operand = w_ff;     end
            3'd1:    begin mac_coef = num_ff[1]; mac_operand = dl_ff[0]; end
            3'd2:    begin mac_coef = num_ff[2]; mac_operand = dl_ff[1]; end
            3'd3:    begin mac_coef = num_ff[3]; mac_operand = dl_ff[2]; end
            default: begin mac_coef = num_ff[4]; mac_operand = dl_ff[3]; end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // clipping of the accumulator to state and sample width
   // ---------------------------------------------------------------------
   always_comb begin
      w_over = (acc > W_MAX) || (acc < W_MIN);
      if (acc > W_MAX) begin
         w_clip = W_MAX[STATE_WIDTH-1:0];
      end else if (acc < W_MIN) begin
         w_clip = W_MIN[STATE_WIDTH-1:0];
      end else begin
         w_clip = acc[STATE_WIDTH-1:0];
      end
      y_over = (acc > Y_MAX) || (acc < Y_MIN);
      if (acc > Y_MAX) begin
         y_clip = Y_MAX[SAMPLE_WIDTH-1:0];
      end else if (acc < Y_MIN) begin
         y_clip = Y_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         y_clip = acc[SAMPLE_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_beat     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      w_in          = w_ff;
      clip_in       = clip_ff;
      dl_in         = dl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      sample_out_in = sample_out_ff;
      saturated_in  = saturated_ff;
      mac_ctrl      = '0;
      mac_load      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               // accumulator starts from the sample
               mac_ctrl.load = 1'b1;
               mac_load      = {{(ACC_WIDTH - SAMPLE_WIDTH){req_if.sample_in[SAMPLE_WIDTH-1]}},
                                req_if.sample_in};
               idx_in        = '0;
               state_in      = S_POLE;
            end
         end
         S_POLE: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.sub   = 1'b1;
            if (idx_ff == IDX_WIDTH'(POLE_COUNT - 1)) begin
               idx_in   = '0;
               state_in = S_PDRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_PDRAIN: begin
            // last pole product lands in the accumulator
            state_in = S_WSAT;
         end
         S_WSAT: begin
            w_in          = w_clip;
            clip_in       = w_over;
            mac_ctrl.load = 1'b1;
            mac_load      = '0;
            idx_in        = '0;
            state_in      = S_ZERO;
         end
         S_ZERO: begin
            mac_ctrl.issue = 1'b1;
            if (idx_ff == IDX_WIDTH'(TAP_COUNT - 1)) begin
               idx_in   = '0;
               state_in = S_ZDRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_ZDRAIN: begin
            state_in = S_YSAT;
         end
         S_YSAT: begin
            // hold here until the output register can take the beat
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               sample_out_in = y_clip;
               saturated_in  = clip_ff || y_over;
               for (int i = POLE_COUNT - 1; i > 0; i--) begin
                  dl_in[i] = dl_ff[i-1];
               end
               dl_in[0] = w_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TAP_COUNT; i++) begin
            num_ff[i] <= '0;
         end
         for (int i = 0; i < POLE_COUNT; i++) begin
            den_ff[i] <= '0;
            dl_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
         dl_ff        <= dl_in;
      end
      w_ff          <= w_in;
      clip_ff       <= clip_in;
      sample_out_ff <= sample_out_in;
      saturated_ff  <= saturated_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = sample_out_ff;
   assign rsp_if.saturated  = saturated_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_accept_starts_poles: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == S_POLE) && (idx_ff == '0))
      else $error("sample beat did not start the pole pass");

   a_zero_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ZERO) |-> (idx_ff <= IDX_WIDTH'(TAP_COUNT - 1)))
      else $error("zero tap index out of range");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_YSAT) |=> $stable(dl_ff[0]) && $stable(dl_ff[3]))
      else $error("delay line moved outside the output step");

   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_YSAT) && out_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished sample did not reach the output register");

endmodule

>>> bench/iir_fourth_order_direct_form_two_unit_tb.sv
// self-checking bench for the fourth-order direct form ii iir filter unit
// drives sample beats and apb-style coefficient writes and checks every result
// depends on iir4_pkg, iir4_stream_if and the iir_fourth_order_direct_form_two_unit rtl
`timescale 1ns / 1ps

module iir_fourth_order_direct_form_two_unit_tb;
   import iir4_pkg::*;

   // coefficient and sample corner values
   localparam int COEF_MAX   = (1 << (COEF_WIDTH - 1)) - 1;
   localparam int COEF_MIN   = -(1 << (COEF_WIDTH - 1));
   localparam int COEF_ONE   = 1 << COEF_FRAC_BITS;
   localparam int COEF_HALF  = 1 << (COEF_FRAC_BITS - 1);
   localparam int SAMPLE_MAX = (1 << (SAMPLE_WIDTH - 1)) - 1;
   localparam int SAMPLE_MIN = -(1 << (SAMPLE_WIDTH - 1));

   // address decodes to index 7, which maps to no register
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;

   // run shape
   localparam int RANDOM_PHASES    = 12;
   localparam int BEATS_PER_PHASE  = 125;
   localparam int FILL_PHASE       = 2;
   localparam int FILL_HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT       = 5000;
   localparam int DRAIN_CYCLES     = 40;

   typedef enum {COEF_STABLE, COEF_EXTREME, COEF_ANY} coef_style_type;
   typedef int num_set_type [TAP_COUNT];
   typedef int den_set_type [POLE_COUNT];

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           saturated;
   } filter_result_type;

   // shadow copy of the filter: coefficients, delay line and the outputs still owed
   class df2_filter_shadow;
      logic signed [COEF_WIDTH-1:0]  num_coef [TAP_COUNT];
      logic signed [COEF_WIDTH-1:0]  den_coef [POLE_COUNT];
      logic signed [STATE_WIDTH-1:0] delay_w  [POLE_COUNT];
      filter_result_type             pending_outputs [$];
      int unsigned                   mismatches;
      bit                            clipped;

      function new();
         foreach (num_coef[i]) num_coef[i] = '0;
         foreach (den_coef[i]) den_coef[i] = '0;
         foreach (delay_w[i]) delay_w[i] = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return pending_outputs.size();
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            REG_NUM_TAP0, REG_NUM_TAP1, REG_NUM_TAP2, REG_NUM_TAP3, REG_NUM_TAP4: begin
               num_coef[index] = value[COEF_WIDTH-1:0];
            end
            REG_DEN_PAIR_LOW: begin
               den_coef[0] = value[COEF_WIDTH-1:0];
               den_coef[1] = value[2*COEF_WIDTH-1:COEF_WIDTH];
            end
            REG_DEN_PAIR_HIGH: begin
               den_coef[2] = value[COEF_WIDTH-1:0];
               den_coef[3] = value[2*COEF_WIDTH-1:COEF_WIDTH];
            end
            default: ;
         endcase
      endfunction

      // product rounded half up at the fraction point
      function longint rounded_product(longint coef, longint state);
         return (coef * state + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      endfunction

      function longint clip(longint v, int width);
         longint top;
         top = (longint'(1) << (width - 1)) - 1;
         if (v > top) begin
            clipped = 1'b1;
            return top;
         end
         if (v < -top - 1) begin
            clipped = 1'b1;
            return -top - 1;
         end
         return v;
      endfunction

      function void take_sample(logic signed [SAMPLE_WIDTH-1:0] u);
         longint            w_next;
         longint            y_sum;
         filter_result_type want;
         clipped = 1'b0;
         w_next = u;
         for (int i = 0; i < POLE_COUNT; i++) w_next -= rounded_product(den_coef[i], delay_w[i]);
         w_next = clip(w_next, STATE_WIDTH);
         y_sum = rounded_product(num_coef[0], w_next);
         for (int i = 0; i < POLE_COUNT; i++)
            y_sum += rounded_product(num_coef[i + 1], delay_w[i]);
         y_sum = clip(y_sum, SAMPLE_WIDTH);
         for (int i = POLE_COUNT - 1; i > 0; i--) delay_w[i] = delay_w[i - 1];
         delay_w[0] = w_next[STATE_WIDTH-1:0];
         want.sample_out = y_sum[SAMPLE_WIDTH-1:0];
         want.saturated  = clipped;
         pending_outputs.push_back(want);
      endfunction

      function void match_output(logic signed [SAMPLE_WIDTH-1:0] got_sample, logic got_sat);
         filter_result_type want;
         if (pending_outputs.size() == 0) begin
            $display("%0t: result beat with no sample outstanding: sample_out %0d saturated %b",
                     $time, got_sample, got_sat);
            mismatches++;
            return;
         end
         want = pending_outputs.pop_front();
         if (got_sample !== want.sample_out) begin
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, want.sample_out, got_sample);
            mismatches++;
         end
         if (got_sat !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, want.saturated, got_sat);
            mismatches++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [CSR_ADDR_WIDTH-1:0]   paddr;
   logic [CSR_DATA_WIDTH-1:0]   pwdata;
   logic [CSR_DATA_WIDTH-1:0]   prdata;
   logic                        pready;

   iir4_req_if req_bus ();
   iir4_rsp_if rsp_bus ();

   df2_filter_shadow shadow;
   bit               calm;          // no idling on either side
   bit               fill_request;  // ask the result side for one long hold-off
   int               idle_cycles;

   iir_fourth_order_direct_form_two_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------

   // apb write with setup and access phases; the register takes the value at the access edge
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0]  value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      shadow.set_register(index, value);
      // idle the bus after each write so back-to-back writes never re-raise psel in one step
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // random junk above the field so the unit has to mask it off
   function automatic logic [CSR_DATA_WIDTH-1:0] with_junk(logic [2*COEF_WIDTH-1:0] field,
                                                           int bits);
      logic [CSR_DATA_WIDTH-1:0] word;
      word = {$urandom, $urandom};
      for (int b = 0; b < bits; b++) word[b] = field[b];
      return word;
   endfunction

   task automatic load_coefficients(input num_set_type num, input den_set_type den,
                                    input bit poke_unmapped);
      write_register(REG_NUM_TAP0, with_junk((2*COEF_WIDTH)'(num[0]), COEF_WIDTH));
      write_register(REG_NUM_TAP1, with_junk((2*COEF_WIDTH)'(num[1]), COEF_WIDTH));
      write_register(REG_NUM_TAP2, with_junk((2*COEF_WIDTH)'(num[2]), COEF_WIDTH));
      write_register(REG_NUM_TAP3, with_junk((2*COEF_WIDTH)'(num[3]), COEF_WIDTH));
      write_register(REG_NUM_TAP4, with_junk((2*COEF_WIDTH)'(num[4]), COEF_WIDTH));
      write_register(REG_DEN_PAIR_LOW,
                     with_junk({den[1][COEF_WIDTH-1:0], den[0][COEF_WIDTH-1:0]}, 2*COEF_WIDTH));
      write_register(REG_DEN_PAIR_HIGH,
                     with_junk({den[3][COEF_WIDTH-1:0], den[2][COEF_WIDTH-1:0]}, 2*COEF_WIDTH));
      // a write past the last register must change nothing
      if (poke_unmapped) write_register(REG_UNMAPPED, {$urandom, $urandom});
   endtask

   // offers one sample beat and returns at the edge that accepts it;
   // valid stays high so the next beat can follow without a bubble
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= value;
      do @(posedge clock); while (!req_bus.ready);
      shadow.take_sample(value);
   endtask

   // drop valid and wait for every owed result so the filter is idle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   function automatic int pick_coef(coef_style_type style, bit pole);
      logic [COEF_WIDTH-1:0] raw;
      case (style)
         COEF_STABLE: begin
            // pole magnitudes sum below one, so the loop stays bounded
            if (pole) return int'($urandom_range(0, 8000)) - 4000;
            return int'($urandom_range(0, 65534)) - 32767;
         end
         COEF_EXTREME: begin
            case ($urandom_range(0, 4))
               0: return COEF_MIN;
               1: return COEF_MAX;
               2: return 0;
               3: return COEF_ONE;
               default: return -COEF_ONE;
            endcase
         end
         default: begin
            raw = COEF_WIDTH'($urandom);
            return $signed(raw);
         end
      endcase
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 9))
         0: v = SAMPLE_MAX;
         1: v = SAMPLE_MIN;
         2, 3: v = int'($urandom_range(0, 510)) - 255;
         default: v = $urandom;
      endcase
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   task automatic configure_filter(input coef_style_type style);
      num_set_type num;
      den_set_type den;
      foreach (num[i]) num[i] = pick_coef(style, 1'b0);
      foreach (den[i]) den[i] = pick_coef(style, 1'b1);
      load_coefficients(num, den, 1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------------------
   // result side: random stalls, one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : result_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (fill_request) begin
            // hold off long enough that the unit backs up and stalls its input
            fill_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (FILL_HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 7);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // every accepted result beat is checked against the oldest owed output
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         shadow.match_output(rsp_bus.sample_out, rsp_bus.saturated);
   end

   // watchdog on cycles with no beat and no bus write
   always @(posedge clock) begin
      if (reset || psel || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
         $display("iir_fourth_order_direct_form_two_unit_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      coef_style_type style;
      shadow = new();
      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // coefficients at reset: output is zero, the delay line still fills
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(0);
      send_sample(-1);
      send_sample(1);
      drain_results();

      // extreme coefficients with large poles: state and output both clip
      load_coefficients('{COEF_MAX, COEF_MIN, COEF_ONE, 0, -COEF_ONE},
                        '{COEF_MIN, COEF_MAX, COEF_ONE, -COEF_ONE}, 1'b1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(0);
      send_sample(SAMPLE_MIN);
      send_sample(1);
      drain_results();

      // half gain, no poles: rounding half up on both signs
      load_coefficients('{COEF_HALF, 0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0);
      send_sample(1);
      send_sample(-1);
      send_sample(3);
      send_sample(-3);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      drain_results();

      // random coefficient sets; the last phase runs without idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         calm  = (phase == RANDOM_PHASES - 1);
         style = calm ? COEF_STABLE : coef_style_type'($urandom_range(0, 2));
         configure_filter(style);
         if (phase == FILL_PHASE) fill_request = 1'b1;
         repeat (BEATS_PER_PHASE) send_sample(pick_sample());
         drain_results();
      end

      // let any stray result beat show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("iir_fourth_order_direct_form_two_unit_tb passed");
      end else begin
         $display("iir_fourth_order_direct_form_two_unit_tb failed");
      end
      $finish;
   end

endmodule
